/* hdl/kcr_pkg.sv */
// kcr_pkg: shared types and constants of the keyed class registry
// no dependencies; imported by the interfaces, the slot ram user and the top level
package kcr_pkg;

   // table geometry
   localparam int ENTRIES = 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // field widths
   localparam int KEY_W = 64;
   localparam int OBJ_W = 64;
   localparam int HDL_W = 32;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_REVOKE   = 2'd1,
      OP_LOOKUP   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_INVALID     = 3'd1,
      ST_ALREADY     = 3'd2,
      ST_FULL        = 3'd3,
      ST_NOT_REG     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   // one slot as stored in the ram
   typedef struct packed {
      logic [KEY_W-1:0] key_high;
      logic [KEY_W-1:0] key_low;
      logic [OBJ_W-1:0] object_ref;
      logic [HDL_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* hdl/kcr_if.sv */
// kcr_req_if, kcr_rsp_if: valid/ready channels of the keyed class registry
// depends on kcr_pkg for field widths
interface kcr_req_if;
   import kcr_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [KEY_W-1:0] key_high;
   logic [KEY_W-1:0] key_low;
   logic [OBJ_W-1:0] object_ref;
   logic [HDL_W-1:0] handle_in;

   modport source (output valid, op, key_high, key_low, object_ref, handle_in,
                   input ready);
   modport sink   (input valid, op, key_high, key_low, object_ref, handle_in,
                   output ready);
endinterface

interface kcr_rsp_if;
   import kcr_pkg::*;

   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic [HDL_W-1:0] handle_out;
   logic [OBJ_W-1:0] object_out;

   modport source (output valid, status, handle_out, object_out, input ready);
   modport sink   (input valid, status, handle_out, object_out, output ready);
endinterface

/* hdl/keyed_class_registry.sv */
// keyed_class_registry: register / revoke / look up over a 32-slot keyed table
// Operation: a scan that runs to the last slot (new key on register, miss on revoke or look up)
//   reads every slot; a key or handle hit ends the scan early; a zero object or unused op
//   answers without a scan. One item at a time; the next item can be taken in the same cycle
//   that the result is presented. The single read port of the slot ram, one slot per cycle,
//   paces the scan.
// Reset (synchronous): all slots free at once, handle counter 1, no clearing pass.
// depends on kcr_pkg, kcr_if.sv, kcr_ram
module keyed_class_registry (
   input  logic       clock,
   input  logic       reset,
   kcr_req_if.sink    req_chan,
   kcr_rsp_if.source  rsp_chan
);
   import kcr_pkg::*;

   state_type        state_ff, state_in;

   // latched request
   op_type           op_ff, op_in;
   logic [KEY_W-1:0] key_hi_ff, key_hi_in;
   logic [KEY_W-1:0] key_lo_ff, key_lo_in;
   logic [OBJ_W-1:0] obj_ff, obj_in;
   logic [HDL_W-1:0] hdl_ff, hdl_in;

   // scan control
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // table state outside the ram
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [HDL_W-1:0]   next_handle_ff, next_handle_in;

   // pending result and output register
   status_type       res_status_ff, res_status_in;
   logic [HDL_W-1:0] res_handle_ff, res_handle_in;
   logic [OBJ_W-1:0] res_object_ff, res_object_in;
   logic             out_vld_ff, out_vld_in;
   status_type       out_status_ff, out_status_in;
   logic [HDL_W-1:0] out_handle_ff, out_handle_in;
   logic [OBJ_W-1:0] out_object_ff, out_object_in;

   // ram ports
   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type        ram_wdata, rd_entry;
   logic [ENTRY_W-1:0] ram_rdata;

   logic             req_xfer, cur_valid, key_hit, hdl_hit, hit, last;

   kcr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry  = entry_type'(ram_rdata);
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // slot compare on the entry read last cycle
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign key_hit   = (rd_entry.key_high == key_hi_ff) && (rd_entry.key_low == key_lo_ff);
   assign hdl_hit   = (rd_entry.handle == hdl_ff);
   assign hit       = cur_valid && ((op_ff == OP_REVOKE) ? hdl_hit : key_hit);
   assign last      = (cmp_idx_ff == IDX_W'(ENTRIES - 1));

   // next state and datapath
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_hi_in      = key_hi_ff;
      key_lo_in      = key_lo_ff;
      obj_in         = obj_ff;
      hdl_in         = hdl_ff;
      issue_cnt_in   = issue_cnt_ff;
      cmp_idx_in     = cmp_idx_ff;
      cmp_vld_in     = 1'b0;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      valid_in       = valid_ff;
      next_handle_in = next_handle_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      res_object_in  = res_object_ff;
      out_vld_in     = out_vld_ff && !rsp_chan.ready;
      out_status_in  = out_status_ff;
      out_handle_in  = out_handle_ff;
      out_object_in  = out_object_ff;
      ram_re         = 1'b0;
      ram_raddr      = issue_cnt_ff[IDX_W-1:0];
      ram_we         = 1'b0;
      ram_waddr      = free_found_ff ? free_idx_ff : cmp_idx_ff;
      ram_wdata      = '{key_high: key_hi_ff, key_low: key_lo_ff,
                         object_ref: obj_ff, handle: next_handle_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in         = op_type'(req_chan.op);
               key_hi_in     = req_chan.key_high;
               key_lo_in     = req_chan.key_low;
               obj_in        = req_chan.object_ref;
               hdl_in        = req_chan.handle_in;
               issue_cnt_in  = '0;
               free_found_in = 1'b0;
               res_handle_in = '0;
               res_object_in = '0;
               res_status_in = ST_INVALID;
               // zero object or unused op answers without a scan
               if ((op_type'(req_chan.op) == OP_RESERVED) ||
                   ((op_type'(req_chan.op) == OP_REGISTER) && (req_chan.object_ref == '0))) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // issue one slot read per cycle
            if (issue_cnt_ff < CNT_W'(ENTRIES)) begin
               ram_re       = 1'b1;
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               cmp_vld_in   = 1'b1;
               cmp_idx_in   = issue_cnt_ff[IDX_W-1:0];
            end
            // evaluate the slot read last cycle
            if (cmp_vld_ff) begin
               if (!cur_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (hit) begin
                  state_in = S_FINISH;
                  case (op_ff)
                     OP_REGISTER: res_status_in = ST_ALREADY;
                     OP_REVOKE: begin
                        res_status_in        = ST_OK;
                        valid_in[cmp_idx_ff] = 1'b0;
                     end
                     OP_LOOKUP: begin
                        res_status_in = ST_OK;
                        res_object_in = rd_entry.object_ref;
                     end
                     default: res_status_in = ST_INVALID;
                  endcase
               end else if (last) begin
                  state_in = S_FINISH;
                  case (op_ff)
                     OP_REGISTER: begin
                        if (free_found_ff || !cur_valid) begin
                           ram_we              = 1'b1;
                           valid_in[ram_waddr] = 1'b1;
                           res_status_in       = ST_OK;
                           res_handle_in       = next_handle_ff;
                           next_handle_in      = next_handle_ff + HDL_W'(1);
                        end else begin
                           res_status_in = ST_FULL;
                        end
                     end
                     OP_LOOKUP: res_status_in = ST_NOT_REG;
                     default:   res_status_in = ST_INVALID;
                  endcase
               end
            end
         end

         S_FINISH: begin
            // move the result into the output register once it is free
            if (!out_vld_ff || rsp_chan.ready) begin
               out_vld_in    = 1'b1;
               out_status_in = res_status_ff;
               out_handle_in = res_handle_ff;
               out_object_in = res_object_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         next_handle_ff <= HDL_W'(1);
         out_vld_ff     <= 1'b0;
         cmp_vld_ff     <= 1'b0;
         issue_cnt_ff   <= '0;
         free_found_ff  <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         next_handle_ff <= next_handle_in;
         out_vld_ff     <= out_vld_in;
         cmp_vld_ff     <= cmp_vld_in;
         issue_cnt_ff   <= issue_cnt_in;
         free_found_ff  <= free_found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_hi_ff     <= key_hi_in;
      key_lo_ff     <= key_lo_in;
      obj_ff        <= obj_in;
      hdl_ff        <= hdl_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_object_ff <= res_object_in;
      out_status_ff <= out_status_in;
      out_handle_ff <= out_handle_in;
      out_object_ff <= out_object_in;
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.handle_out = out_handle_ff;
   assign rsp_chan.object_out = out_object_ff;

   // the slot ram is written only at the end of a register scan
   a_write_on_register: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN) && (op_ff == OP_REGISTER) && cmp_vld_ff)
      else $error("slot write outside a register scan");

   // the handle counter advances only together with a slot write
   a_handle_with_write: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (next_handle_ff != $past(next_handle_ff))) |-> $past(ram_we))
      else $error("handle counter moved without a slot write");

   // failed results carry zero handle and object
   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_status_ff != ST_OK)) |-> (out_handle_ff == '0) && (out_object_ff == '0))
      else $error("failed result with nonzero payload");

   // at most one slot changes per cycle
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(valid_ff ^ $past(valid_ff)) <= 1))
      else $error("more than one slot changed in a cycle");

endmodule

/* hdl/kcr_ram.sv */
// kcr_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module kcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* tb/keyed_class_registry_tb.sv */
// keyed_class_registry_tb: self-checking bench for the keyed class registry
// directed table then random register / revoke / look up traffic, checked against a local
// model of the slot table; depends on kcr_pkg, kcr_if.sv and the keyed_class_registry rtl
module keyed_class_registry_tb;
   import kcr_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASES       = 4;
   localparam int KEY_POOL     = 40;
   localparam int TAIL_CYCLES  = ENTRIES + 8;

   localparam logic [63:0] Z64 = 64'h0;
   localparam logic [63:0] F64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] Z32 = 32'h0;
   localparam logic [31:0] F32 = 32'hFFFF_FFFF;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key_high;
      logic [KEY_W-1:0] key_low;
      logic [OBJ_W-1:0] object_ref;
      logic [HDL_W-1:0] handle_in;
   } request_type;

   typedef struct packed {
      status_type       status;
      logic [HDL_W-1:0] handle_out;
      logic [OBJ_W-1:0] object_out;
   } answer_type;

   typedef struct packed {
      request_type stim;
      logic        typed_in;
      answer_type  want;
   } directed_row_type;

   localparam answer_type PREDICTED = '{ST_OK, Z32, Z64};

   logic clock;
   logic reset;

   kcr_req_if req_chan ();
   kcr_rsp_if rsp_chan ();

   keyed_class_registry uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // local copy of the slot table
   logic             tbl_live   [ENTRIES];
   logic [KEY_W-1:0] tbl_key_hi [ENTRIES];
   logic [KEY_W-1:0] tbl_key_lo [ENTRIES];
   logic [OBJ_W-1:0] tbl_obj    [ENTRIES];
   logic [HDL_W-1:0] tbl_handle [ENTRIES];
   logic [HDL_W-1:0] handle_counter;

   // keys shared by random items so hits and duplicates occur
   logic [KEY_W-1:0] pool_key_hi [KEY_POOL];
   logic [KEY_W-1:0] pool_key_lo [KEY_POOL];

   answer_type       pending_answers [$];
   directed_row_type directed_table [25];
   int               mismatches;
   int               sender_idle_pct;
   int               receiver_stall_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("** keyed_class_registry: FAILED **");
      $finish;
   end

   function automatic int slot_of_key(input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo);
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_live[i] && tbl_key_hi[i] == hi && tbl_key_lo[i] == lo) return i;
      end
      return -1;
   endfunction

   // table update and answer for one accepted request
   function automatic answer_type registry_apply(input request_type it);
      answer_type ans;
      int         hit;
      ans = '{ST_INVALID, Z32, Z64};
      case (it.op)
         OP_REGISTER: begin
            if (it.object_ref == '0) begin
               ans.status = ST_INVALID;
            end else if (slot_of_key(it.key_high, it.key_low) >= 0) begin
               ans.status = ST_ALREADY;
            end else begin
               ans.status = ST_FULL;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!tbl_live[i]) begin
                     tbl_live[i]    = 1'b1;
                     tbl_key_hi[i]  = it.key_high;
                     tbl_key_lo[i]  = it.key_low;
                     tbl_obj[i]     = it.object_ref;
                     tbl_handle[i]  = handle_counter;
                     ans.handle_out = handle_counter;
                     ans.status     = ST_OK;
                     handle_counter = handle_counter + 1'b1;
                     break;
                  end
               end
            end
         end
         OP_REVOKE: begin
            // lowest matching live slot only
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_live[i] && tbl_handle[i] == it.handle_in) begin
                  tbl_live[i]   = 1'b0;
                  tbl_obj[i]    = '0;
                  tbl_handle[i] = '0;
                  ans.status    = ST_OK;
                  break;
               end
            end
         end
         OP_LOOKUP: begin
            hit = slot_of_key(it.key_high, it.key_low);
            if (hit >= 0) begin
               ans.status     = ST_OK;
               ans.object_out = tbl_obj[hit];
            end else begin
               ans.status = ST_NOT_REG;
            end
         end
         default: ans.status = ST_INVALID;
      endcase
      return ans;
   endfunction

   // random request, biased toward filling or draining the table
   function automatic request_type random_request(input bit filling);
      request_type it;
      int          pick;
      int          k;
      int          live [$];
      pick          = $urandom_range(99);
      it.key_high   = {$urandom, $urandom};
      it.key_low    = {$urandom, $urandom};
      it.object_ref = {$urandom, $urandom};
      it.handle_in  = $urandom;
      if (pick < 4) begin
         it.op = OP_RESERVED;
      end else if (pick < (filling ? 70 : 25)) begin
         it.op = OP_REGISTER;
      end else if (pick < (filling ? 82 : 80)) begin
         it.op = OP_REVOKE;
      end else begin
         it.op = OP_LOOKUP;
      end
      if ($urandom_range(9) != 0) begin
         k           = $urandom_range(KEY_POOL - 1);
         it.key_high = pool_key_hi[k];
         it.key_low  = pool_key_lo[k];
      end
      if (it.op == OP_REGISTER && $urandom_range(19) == 0) it.object_ref = '0;
      if (it.op == OP_REVOKE) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_live[i]) live.push_back(i);
         end
         k = $urandom_range(9);
         if (live.size() != 0 && k < 7) begin
            it.handle_in = tbl_handle[live[$urandom_range(live.size() - 1)]];
         end else if (k < 9) begin
            it.handle_in = $urandom_range(handle_counter + 2);
         end
      end
      return it;
   endfunction

   // one transfer on the request channel, called and left at a falling edge
   task automatic drive_item(input request_type it, input logic typed_in,
                             input answer_type want);
      answer_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.op         = it.op;
      req_chan.key_high   = it.key_high;
      req_chan.key_low    = it.key_low;
      req_chan.object_ref = it.object_ref;
      req_chan.handle_in  = it.handle_in;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = registry_apply(it);
      pending_answers.push_back(typed_in ? want : predicted);
      @(negedge clock);
   endtask

   // sender holds off until every answer is back
   task automatic hold_until_drained;
      req_chan.valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // receiver side: random stalls per cycle
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // answer check at each transfer on the result channel
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected answer, expected none, actual status %0d", $time,
                     rsp_chan.status);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        want.status, rsp_chan.status);
               mismatches++;
            end
            if (rsp_chan.handle_out !== want.handle_out) begin
               $display("%0t: handle_out mismatch, expected %h, actual %h", $time,
                        want.handle_out, rsp_chan.handle_out);
               mismatches++;
            end
            if (rsp_chan.object_out !== want.object_out) begin
               $display("%0t: object_out mismatch, expected %h, actual %h", $time,
                        want.object_out, rsp_chan.object_out);
               mismatches++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      idle_mode_type mode;
      bit            filling;
      int            chunk_left;
      mismatches          = 0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_REGISTER;
      req_chan.key_high   = '0;
      req_chan.key_low    = '0;
      req_chan.object_ref = '0;
      req_chan.handle_in  = '0;
      handle_counter      = 32'd1;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_live[i]   = 1'b0;
         tbl_key_hi[i] = '0;
         tbl_key_lo[i] = '0;
         tbl_obj[i]    = '0;
         tbl_handle[i] = '0;
      end
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_key_hi[i] = {$urandom, $urandom};
         pool_key_lo[i] = {$urandom, $urandom};
      end

      // directed rows: stimulus, typed-in flag, answer where typed in
      directed_table = '{
         '{'{OP_LOOKUP,   Z64, Z64, Z64, Z32}, 1'b1, '{ST_NOT_REG, Z32, Z64}},
         '{'{OP_REVOKE,   Z64, Z64, Z64, Z32}, 1'b1, '{ST_INVALID, Z32, Z64}},
         '{'{OP_REVOKE,   Z64, Z64, Z64, F32}, 1'b1, '{ST_INVALID, Z32, Z64}},
         '{'{OP_REGISTER, Z64, Z64, Z64, Z32}, 1'b1, '{ST_INVALID, Z32, Z64}},
         '{'{OP_REGISTER, Z64, Z64, 64'h1, Z32}, 1'b1, '{ST_OK, 32'd1, Z64}},
         '{'{OP_REGISTER, F64, F64, F64, F32}, 1'b1, '{ST_OK, 32'd2, Z64}},
         '{'{OP_REGISTER, Z64, Z64, 64'h5, Z32}, 1'b1, '{ST_ALREADY, Z32, Z64}},
         '{'{OP_LOOKUP,   Z64, Z64, Z64, Z32}, 1'b1, '{ST_OK, Z32, 64'h1}},
         '{'{OP_LOOKUP,   F64, F64, Z64, Z32}, 1'b1, '{ST_OK, Z32, F64}},
         '{'{OP_RESERVED, F64, F64, F64, F32}, 1'b1, '{ST_INVALID, Z32, Z64}},
         '{'{OP_RESERVED, Z64, Z64, Z64, Z32}, 1'b1, '{ST_INVALID, Z32, Z64}},
         '{'{OP_REGISTER, F64, Z64, 64'h8000_0000_0000_0000, Z32}, 1'b1,
           '{ST_OK, 32'd3, Z64}},
         '{'{OP_REGISTER, Z64, F64, 64'h0000_0001_0000_0000, Z32}, 1'b0, PREDICTED},
         '{'{OP_LOOKUP,   F64, Z64, Z64, Z32}, 1'b1,
           '{ST_OK, Z32, 64'h8000_0000_0000_0000}},
         '{'{OP_LOOKUP,   Z64, 64'h1, Z64, Z32}, 1'b1, '{ST_NOT_REG, Z32, Z64}},
         '{'{OP_REVOKE,   Z64, Z64, Z64, 32'd2}, 1'b1, '{ST_OK, Z32, Z64}},
         '{'{OP_LOOKUP,   F64, F64, Z64, Z32}, 1'b1, '{ST_NOT_REG, Z32, Z64}},
         '{'{OP_REVOKE,   Z64, Z64, Z64, 32'd2}, 1'b1, '{ST_INVALID, Z32, Z64}},
         '{'{OP_REGISTER, F64, F64, 64'h1234, Z32}, 1'b0, PREDICTED},
         '{'{OP_LOOKUP,   F64, F64, Z64, Z32}, 1'b0, PREDICTED},
         '{'{OP_REVOKE,   Z64, Z64, Z64, 32'd1}, 1'b0, PREDICTED},
         '{'{OP_REGISTER, Z64, Z64, 64'hA5A5_5A5A_0F0F_F0F0, 32'hDEAD_BEEF}, 1'b0,
           PREDICTED},
         '{'{OP_LOOKUP,   Z64, Z64, F64, F32}, 1'b0, PREDICTED},
         '{'{OP_REVOKE,   F64, F64, Z64, 32'd4}, 1'b0, PREDICTED},
         '{'{OP_LOOKUP,   Z64, F64, Z64, Z32}, 1'b0, PREDICTED}
      };

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed part with no idling
      foreach (directed_table[i]) begin
         drive_item(directed_table[i].stim, directed_table[i].typed_in,
                    directed_table[i].want);
      end

      // random part, one idling mode per phase
      filling    = 1'b1;
      chunk_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         mode = idle_mode_type'(phase);
         hold_until_drained();
         case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
            default:       begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // alternate stretches that fill and drain the table
            if (chunk_left == 0) begin
               filling    = ~filling;
               chunk_left = filling ? $urandom_range(90, 50) : $urandom_range(80, 40);
            end
            chunk_left--;
            if ($urandom_range(99) == 0) hold_until_drained();
            drive_item(random_request(filling), 1'b0, PREDICTED);
         end
      end

      // wind down
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("** keyed_class_registry: PASSED **");
      end else begin
         $display("** keyed_class_registry: FAILED **");
      end
      $finish;
   end

endmodule
